### rtl/splm_pkg.sv
// Shared types and codes for the slot pool linked list manager.
// Used by splm_ctrl, splm_datapath and slot_pool_linked_list_manager_unit.
package splm_pkg;

  // Operation codes carried in the func field.
  localparam logic [1:0] FUNC_INIT   = 2'd0;
  localparam logic [1:0] FUNC_ALLOC  = 2'd1;
  localparam logic [1:0] FUNC_REMOVE = 2'd2;

  // Result status codes.
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_DUMMY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;
  localparam logic [1:0] STAT_HEAD  = 2'd3;

  typedef struct packed {
    logic [1:0] func;
    logic       use_dummy;
    logic [5:0] slot;
  } splm_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  slot_out;
    logic [15:0] alloc_count;
  } splm_rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       alloc_start;
    logic       alloc_fin;
    logic       rem_start;
    logic       rem_unlink;
    logic       rem_fix;
    logic       init_start;
    logic       init_step;
    logic       init_fin;
    logic       res_we;
    logic [1:0] res_status;
    logic       res_slot;
  } splm_cmd_t;

  // Status flags from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic rem_head;
    logic rem_in_range;
    logic rem_active;
    logic rem_tail;
    logic rem_next_slot;
    logic init_last;
  } splm_stat_t;

endpackage

### rtl/splm_ctrl.sv
// Controller state machine of the slot pool linked list manager.
// Depends on splm_pkg; drives the command struct of splm_datapath.
module splm_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  splm_pkg::splm_req_t   req_i,
  input  splm_pkg::splm_stat_t  stat_i,
  output splm_pkg::splm_cmd_t   cmd_o,
  output logic                  busy_o,
  output logic                  valid_o
);

  typedef enum logic [2:0] {
    IDLE,
    ALLOC,
    REM_READ,
    REM_FIX,
    INIT_SWEEP
  } state_e;

  state_e state_d, state_q;
  logic   valid_q;

  assign busy_o  = (state_q != IDLE);
  assign valid_o = valid_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      IDLE: begin
        if (start_i) begin
          case (req_i.func)
            splm_pkg::FUNC_INIT: begin
              cmd_o.init_start = 1'b1;
              state_d          = INIT_SWEEP;
            end
            splm_pkg::FUNC_ALLOC: begin
              if (stat_i.full) begin
                cmd_o.res_we     = 1'b1;
                cmd_o.res_status = req_i.use_dummy ? splm_pkg::STAT_DUMMY
                                                   : splm_pkg::STAT_FULL;
              end else begin
                cmd_o.alloc_start = 1'b1;
                state_d           = ALLOC;
              end
            end
            splm_pkg::FUNC_REMOVE: begin
              if (stat_i.rem_head) begin
                cmd_o.res_we     = 1'b1;
                cmd_o.res_status = splm_pkg::STAT_HEAD;
              end else if (!stat_i.rem_in_range) begin
                // Slot outside the pool or pool never built: nothing to unlink.
                cmd_o.res_we     = 1'b1;
                cmd_o.res_status = splm_pkg::STAT_OK;
              end else begin
                cmd_o.rem_start = 1'b1;
                state_d         = REM_READ;
              end
            end
            default: begin
              cmd_o.res_we     = 1'b1;
              cmd_o.res_status = splm_pkg::STAT_OK;
            end
          endcase
        end
      end
      ALLOC: begin
        cmd_o.alloc_fin  = 1'b1;
        cmd_o.res_we     = 1'b1;
        cmd_o.res_status = splm_pkg::STAT_OK;
        cmd_o.res_slot   = 1'b1;
        state_d          = IDLE;
      end
      REM_READ: begin
        if (!stat_i.rem_active) begin
          cmd_o.res_we     = 1'b1;
          cmd_o.res_status = splm_pkg::STAT_OK;
          state_d          = IDLE;
        end else begin
          cmd_o.rem_unlink = 1'b1;
          // The successor's back link needs the prev link port a second time.
          if (!stat_i.rem_tail && stat_i.rem_next_slot) begin
            state_d = REM_FIX;
          end else begin
            cmd_o.res_we     = 1'b1;
            cmd_o.res_status = splm_pkg::STAT_OK;
            state_d          = IDLE;
          end
        end
      end
      REM_FIX: begin
        cmd_o.rem_fix    = 1'b1;
        cmd_o.res_we     = 1'b1;
        cmd_o.res_status = splm_pkg::STAT_OK;
        state_d          = IDLE;
      end
      INIT_SWEEP: begin
        cmd_o.init_step = 1'b1;
        if (stat_i.init_last) begin
          cmd_o.init_fin   = 1'b1;
          cmd_o.res_we     = 1'b1;
          cmd_o.res_status = splm_pkg::STAT_OK;
          state_d          = IDLE;
        end
      end
      default: begin
        state_d = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= cmd_o.res_we;
    end
  end

endmodule

### rtl/splm_datapath.sv
// Datapath of the slot pool linked list manager: link memories, list
// pointers, allocation counter and result register. Depends on splm_pkg.
module splm_datapath #(
  parameter int MAX_ENTRIES = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  splm_pkg::splm_req_t   req_i,
  input  splm_pkg::splm_cmd_t   cmd_i,
  output splm_pkg::splm_stat_t  stat_o,
  output splm_pkg::splm_rsp_t   rsp_o
);

  localparam int IW  = $clog2(MAX_ENTRIES);
  localparam int LW  = IW + 1;
  localparam int CW  = (LW > 6) ? LW : 6;
  localparam logic [LW-1:0] NIL = LW'(MAX_ENTRIES);

  // Link memories and active flags, one entry per slot.
  logic [LW-1:0] prev_mem [MAX_ENTRIES];
  logic [LW-1:0] next_mem [MAX_ENTRIES];
  logic          act_mem  [MAX_ENTRIES];

  logic [LW-1:0] prev_rd_q, next_rd_q;
  logic          act_rd_q;

  logic [LW-1:0] free_head_q, free_head_d;
  logic [LW-1:0] tail_q, tail_d;
  logic [LW-1:0] head_q, head_d;
  logic [15:0]   count_q, count_d;
  logic          init_done_q, init_done_d;
  logic [IW-1:0] s_q, n_q, ctr_q;
  splm_pkg::splm_rsp_t res_q;

  logic [CW-1:0] slot_ext;
  logic [IW-1:0] slot_idx;

  logic          prev_we, next_we, act_we;
  logic [IW-1:0] prev_wa, next_wa, act_wa;
  logic [LW-1:0] prev_wd, next_wd;
  logic          act_wd;
  logic [IW-1:0] prev_ra;

  assign slot_ext = CW'(req_i.slot);
  assign slot_idx = IW'(req_i.slot);

  assign stat_o.full          = !(free_head_q < NIL);
  assign stat_o.rem_head      = (slot_ext == CW'(head_q));
  assign stat_o.rem_in_range  = init_done_q && (slot_ext < CW'(MAX_ENTRIES));
  assign stat_o.rem_active    = act_rd_q;
  assign stat_o.rem_tail      = (LW'(s_q) == tail_q);
  assign stat_o.rem_next_slot = (next_rd_q < NIL);
  assign stat_o.init_last     = (ctr_q == IW'(MAX_ENTRIES - 1));

  // Each memory takes at most one write per cycle; the controller orders them.
  always_comb begin
    prev_we = 1'b0;
    prev_wa = ctr_q;
    prev_wd = NIL;
    next_we = 1'b0;
    next_wa = ctr_q;
    next_wd = NIL;
    act_we  = 1'b0;
    act_wa  = ctr_q;
    act_wd  = 1'b0;
    if (cmd_i.init_step) begin
      // Slot 0 becomes the head; every other slot links to the one above it.
      prev_we = 1'b1;
      prev_wd = (ctr_q == '0) ? NIL : (LW'(ctr_q) + LW'(1));
      next_we = 1'b1;
      act_we  = 1'b1;
      act_wd  = (ctr_q == '0);
    end
    if (cmd_i.alloc_start && (tail_q < NIL)) begin
      next_we = 1'b1;
      next_wa = tail_q[IW-1:0];
      next_wd = free_head_q;
    end
    if (cmd_i.alloc_fin) begin
      prev_we = 1'b1;
      prev_wa = n_q;
      prev_wd = tail_q;
      next_we = 1'b1;
      next_wa = n_q;
      next_wd = NIL;
      act_we  = 1'b1;
      act_wa  = n_q;
      act_wd  = 1'b1;
    end
    if (cmd_i.rem_unlink) begin
      prev_we = 1'b1;
      prev_wa = s_q;
      prev_wd = free_head_q;
      act_we  = 1'b1;
      act_wa  = s_q;
      act_wd  = 1'b0;
      if (prev_rd_q < NIL) begin
        next_we = 1'b1;
        next_wa = prev_rd_q[IW-1:0];
        next_wd = next_rd_q;
      end
    end
    if (cmd_i.rem_fix) begin
      prev_we = 1'b1;
      prev_wa = next_rd_q[IW-1:0];
      prev_wd = prev_rd_q;
    end
  end

  assign prev_ra = cmd_i.alloc_start ? free_head_q[IW-1:0] : slot_idx;

  always_ff @(posedge clk_i) begin
    if (prev_we) begin
      prev_mem[prev_wa] <= prev_wd;
    end
    if (cmd_i.alloc_start || cmd_i.rem_start) begin
      prev_rd_q <= prev_mem[prev_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (next_we) begin
      next_mem[next_wa] <= next_wd;
    end
    if (cmd_i.rem_start) begin
      next_rd_q <= next_mem[slot_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (act_we) begin
      act_mem[act_wa] <= act_wd;
    end
    if (cmd_i.rem_start) begin
      act_rd_q <= act_mem[slot_idx];
    end
  end

  always_comb begin
    free_head_d = free_head_q;
    tail_d      = tail_q;
    head_d      = head_q;
    count_d     = count_q;
    init_done_d = init_done_q;
    if (cmd_i.alloc_fin) begin
      free_head_d = prev_rd_q;
      tail_d      = LW'(n_q);
      count_d     = (count_q != 16'hFFFF) ? (count_q + 16'd1) : count_q;
    end
    if (cmd_i.rem_unlink) begin
      free_head_d = LW'(s_q);
      if (LW'(s_q) == tail_q) begin
        tail_d = prev_rd_q;
      end
    end
    if (cmd_i.init_fin) begin
      free_head_d = LW'(1);
      tail_d      = '0;
      head_d      = '0;
      count_d     = 16'd1;
      init_done_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_head_q <= NIL;
      tail_q      <= NIL;
      head_q      <= NIL;
      count_q     <= '0;
      init_done_q <= 1'b0;
    end else begin
      free_head_q <= free_head_d;
      tail_q      <= tail_d;
      head_q      <= head_d;
      count_q     <= count_d;
      init_done_q <= init_done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.alloc_start) begin
      n_q <= free_head_q[IW-1:0];
    end
    if (cmd_i.rem_start) begin
      s_q <= slot_idx;
    end
    if (cmd_i.init_start) begin
      ctr_q <= '0;
    end else if (cmd_i.init_step) begin
      ctr_q <= ctr_q + IW'(1);
    end
    if (cmd_i.res_we) begin
      res_q.status      <= cmd_i.res_status;
      res_q.slot_out    <= cmd_i.res_slot ? 6'(n_q) : 6'd0;
      res_q.alloc_count <= count_d;
    end
  end

  assign rsp_o = res_q;

endmodule

### rtl/slot_pool_linked_list_manager_unit.sv
// Top level of the slot pool linked list manager.
// Depends on splm_pkg, splm_ctrl and splm_datapath.
//
// Usage: drive req_i and raise start; the item is taken at a clock edge where
// start is high and busy is low. Exactly one result follows per item, shown
// on rsp_o for one cycle with result_valid_o high; it cannot be held off.
// Results leave in the order items were taken.
// Steps from the accepting edge to the result:
//   unused func code, full pool, head removal, or removal of a slot outside
//   the pool or before the first init: result registered at accept, and
//   busy stays low, so such items can follow one per cycle;
//   allocate: prev link read at accept, then the writes in ALLOC;
//   remove of any other slot: links read at accept, unlink in REM_READ, plus
//   REM_FIX when an active slot's successor needs its back link rewritten,
//   since each link memory has a single write port;
//   init: INIT_SWEEP over every slot, one link memory entry written per cycle.
// A new item may be accepted in the cycle its predecessor's result is shown.
// Reset empties both lists; the pool must be built by an init item before
// allocations succeed. Link memory contents are undefined until that init.
module slot_pool_linked_list_manager_unit #(
  parameter int MAX_ENTRIES = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  splm_pkg::splm_req_t  req_i,
  output logic                 result_valid_o,
  output splm_pkg::splm_rsp_t  rsp_o
);

  splm_pkg::splm_cmd_t  cmd;
  splm_pkg::splm_stat_t stat;

  splm_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .req_i   (req_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .valid_o (result_valid_o)
  );

  splm_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cmd_i  (cmd),
    .stat_o (stat),
    .rsp_o  (rsp_o)
  );

endmodule
